// ----- rtl/xcfp_pkg.sv -----
// Package for the XOR-checked command frame parser.
// Holds the parse phase type, result status codes and keyword bytes.
// No dependencies.
package xcfp_pkg;

  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_CMD  = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_SUM  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_HUNT = 3'd0,
    ST_ACC  = 3'd1,
    ST_DATA = 3'd2,
    ST_GOOD = 3'd3,
    ST_BAD  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    DOOR_NONE  = 2'd0,
    DOOR_OPEN  = 2'd1,
    DOOR_CLOSE = 2'd2
  } door_t;

  localparam int unsigned KEEP_BYTES = 5;
  localparam int unsigned KEEP_IDX_W = 3;

  localparam logic [7:0] KW_OPEN  [4] = '{8'h4F, 8'h50, 8'h45, 8'h4E};
  localparam logic [7:0] KW_CLOSE [5] = '{8'h43, 8'h4C, 8'h4F, 8'h53, 8'h45};

  localparam logic [7:0] HDR_FIRST_RST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND_RST = 8'hDD;

  localparam logic CFG_HDR_FIRST  = 1'b0;
  localparam logic CFG_HDR_SECOND = 1'b1;

endpackage

// ----- rtl/xor_checked_command_frame_parser.sv -----
// Top level of the XOR-checked command frame parser.
// Uses xcfp_pkg for phase, status and keyword definitions.
// The result is registered: it is valid in the cycle after the input transfer.
// Throughput: one byte per cycle unless a held result is not taken; the result register frees while a result is taken.
// Reset (rst_n low, synchronous): hunt for first header, counters, XOR,
// command, length and kept payload cleared; header bytes return to 0xAA and 0xDD.
module xor_checked_command_frame_parser
  import xcfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] byte_out, [15:8] command,
                                  // [23:16] payload_len, [25:24] door_action
  output logic [2:0]  out_tuser   // [2:0] status
);

  logic [7:0] hdr_first_r;
  logic [7:0] hdr_second_r;
  phase_t     phase_r, phase_nxt;
  logic [7:0] bytes_read_r, bytes_read_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] lead_r [KEEP_BYTES];
  logic       lead_we;
  logic [7:0] bytes_inc;

  logic       out_valid_r;
  logic [7:0] byte_out_r;
  status_t    status_r, status_nxt;
  door_t      door_r, door_nxt;

  logic       accept;
  logic [7:0] b;
  logic       open_hit, close_hit;

  assign b         = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign bytes_inc = bytes_read_r + 8'd1;
  assign lead_we   = (phase_r == PH_DATA) && (bytes_read_r < 8'(KEEP_BYTES));

  always_comb begin
    open_hit = (len_r >= 8'd4);
    for (int i = 0; i < 4; i++) begin
      if (lead_r[i] != KW_OPEN[i]) open_hit = 1'b0;
    end
    close_hit = (len_r >= 8'd5);
    for (int i = 0; i < 5; i++) begin
      if (lead_r[i] != KW_CLOSE[i]) close_hit = 1'b0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HDR1: if (b == hdr_first_r) phase_nxt = PH_HDR2;
      PH_HDR2: phase_nxt = (b == hdr_second_r) ? PH_CMD : PH_HDR1;
      PH_CMD:  phase_nxt = PH_LEN;
      PH_LEN:  phase_nxt = (b == 8'd0) ? PH_SUM : PH_DATA;
      PH_DATA: if (bytes_inc >= len_r) phase_nxt = PH_SUM;
      PH_SUM:  phase_nxt = PH_HDR1;
      default: phase_nxt = PH_HDR1;
    endcase
  end

  always_comb begin
    bytes_read_nxt = bytes_read_r;
    xor_nxt        = xor_r;
    cmd_nxt        = cmd_r;
    len_nxt        = len_r;
    status_nxt     = ST_HUNT;
    door_nxt       = DOOR_NONE;
    unique case (phase_r)
      PH_HDR1: begin
        if (b == hdr_first_r) begin
          xor_nxt        = b;
          bytes_read_nxt = 8'd0;
          status_nxt     = ST_ACC;
        end
      end
      PH_HDR2: begin
        if (b == hdr_second_r) begin
          xor_nxt    = xor_r ^ b;
          status_nxt = ST_ACC;
        end else begin
          xor_nxt        = 8'd0;
          bytes_read_nxt = 8'd0;
        end
      end
      PH_CMD: begin
        cmd_nxt    = b;
        xor_nxt    = xor_r ^ b;
        status_nxt = ST_ACC;
      end
      PH_LEN: begin
        len_nxt        = b;
        xor_nxt        = xor_r ^ b;
        bytes_read_nxt = 8'd0;
        status_nxt     = ST_ACC;
      end
      PH_DATA: begin
        xor_nxt        = xor_r ^ b;
        bytes_read_nxt = bytes_inc;
        status_nxt     = ST_DATA;
      end
      PH_SUM: begin
        if (b == xor_r) begin
          status_nxt = ST_GOOD;
          if (open_hit)       door_nxt = DOOR_OPEN;
          else if (close_hit) door_nxt = DOOR_CLOSE;
        end else begin
          status_nxt = ST_BAD;
        end
        xor_nxt        = 8'd0;
        bytes_read_nxt = 8'd0;
      end
      default: begin
        xor_nxt        = 8'd0;
        bytes_read_nxt = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= HDR_FIRST_RST;
      hdr_second_r <= HDR_SECOND_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_HDR_FIRST) hdr_first_r  <= cfg_wdata;
      else                            hdr_second_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR1;
      bytes_read_r <= 8'd0;
      xor_r        <= 8'd0;
      cmd_r        <= 8'd0;
      len_r        <= 8'd0;
      for (int i = 0; i < KEEP_BYTES; i++) lead_r[i] <= 8'd0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      bytes_read_r <= bytes_read_nxt;
      xor_r        <= xor_nxt;
      cmd_r        <= cmd_nxt;
      len_r        <= len_nxt;
      if (lead_we) lead_r[bytes_read_r[KEEP_IDX_W-1:0]] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_out_r <= b;
      status_r   <= status_nxt;
      door_r     <= door_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {6'd0, door_r, len_r, cmd_r, byte_out_r};

  a_reset_hunt: assert property (@(posedge clk) !rst_n |=> phase_r == PH_HDR1)
    else $error("phase not cleared by reset");

  a_sum_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_SUM |=> phase_r == PH_HDR1 && xor_r == 8'd0)
    else $error("checksum byte did not restart hunting");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> bytes_read_r < len_r)
    else $error("payload count reached length inside payload phase");

  a_door_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && door_r != DOOR_NONE |-> status_r == ST_GOOD)
    else $error("door action without good frame");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

endmodule
